// File: rtl/skt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Beat formats, command and status codes, sequencer states, key normalizer.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_CHARS = 8;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int KEY_W  = 64;
  localparam int TIME_W = 17;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_EXISTS = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_COUNT  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_DUP     = 2'd1,
    STS_FULL    = 2'd2,
    STS_BAD_POS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SH0,
    ST_SHIFT,
    ST_DL0,
    ST_DSHIFT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] plate_key;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [6:0]  position;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [6:0] entry_count;
  } out_beat_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] tod;
  } entry_t;

  // keep the leading KEY_CHARS bytes, zero everything after the first NUL
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    logic             ended;
    logic [7:0]       b;
    r     = '0;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      b = k[KEY_W-1-8*i -: 8];
      if (i >= KEY_CHARS || b == 8'h00) begin
        ended = 1'b1;
      end
      if (!ended) begin
        r[KEY_W-1-8*i -: 8] = b;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sorted_key_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table: ordered table of plate keys with time of day
// Simple dual-port entry memory driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// One command is taken at a time; in_stall is high until its result beat is
// loaded into the output register. Entries live in one memory (one read,
// one write per cycle, registered read). Exists and insert walk the table
// from slot 0, one entry per cycle, until the first key not below the
// queried one or the end of the table. Insert then moves the tail up one
// entry per cycle from the top and writes the new entry into the freed slot.
// Delete moves the tail down one entry per cycle. Count, clear, unused codes
// and a rejected delete go straight to the response state; a rejected
// insert goes there after its walk. The longest command is an accepted
// insert into a table of CAPACITY-1 entries; any result also waits in the
// response state while out_stall holds the output register.
// ----------------------------------------------------------------------------
module sorted_key_table (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire skt_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output skt_pkg::out_beat_t     out_data
);

  skt_pkg::state_t  state_r, state_nxt;
  skt_pkg::cmd_t    cmd_r, cmd_nxt;
  skt_pkg::status_t status_r, status_nxt;
  logic                          found_r, found_nxt;
  logic [skt_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [skt_pkg::TIME_W-1:0]    tod_r, tod_nxt;
  logic [skt_pkg::CNT_W-1:0]     used_r, used_nxt;
  logic [skt_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic [skt_pkg::CNT_W-1:0]     slot_r, slot_nxt;
  logic                          out_valid_r, out_valid_nxt;
  skt_pkg::out_beat_t            out_data_r, out_data_nxt;

  skt_pkg::entry_t               mem [skt_pkg::CAPACITY];
  skt_pkg::entry_t               rdata_r;
  logic                          mem_we;
  logic [skt_pkg::IDX_W-1:0]     waddr, raddr;
  skt_pkg::entry_t               wdata;

  skt_pkg::cmd_t                 in_cmd;
  logic                          pos_bad;
  logic                          hit_end, stop, match;
  logic                          can_load;
  logic [skt_pkg::CNT_W-1:0]     idx_p1, idx_p2, idx_m1, idx_m2;

  assign in_cmd   = skt_pkg::cmd_t'(in_data.cmd);
  assign pos_bad  = (in_data.position == 7'd0) || (32'(in_data.position) > 32'(used_r));
  assign hit_end  = (idx_r == used_r);
  assign stop     = hit_end || (rdata_r.key >= key_r);
  assign match    = !hit_end && (rdata_r.key == key_r);
  assign can_load = !out_valid_r || !out_stall;
  assign idx_p1   = idx_r + skt_pkg::CNT_W'(1);
  assign idx_p2   = idx_r + skt_pkg::CNT_W'(2);
  assign idx_m1   = idx_r - skt_pkg::CNT_W'(1);
  assign idx_m2   = idx_r - skt_pkg::CNT_W'(2);

  assign in_stall  = (state_r != skt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skt_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            skt_pkg::CMD_INSERT, skt_pkg::CMD_EXISTS: state_nxt = skt_pkg::ST_SRCH;
            skt_pkg::CMD_DELETE: state_nxt = pos_bad ? skt_pkg::ST_RESP : skt_pkg::ST_DL0;
            default: state_nxt = skt_pkg::ST_RESP;
          endcase
        end
      end
      skt_pkg::ST_SRCH: begin
        if (stop) begin
          if (cmd_r == skt_pkg::CMD_EXISTS || match ||
              32'(used_r) >= skt_pkg::CAPACITY) begin
            state_nxt = skt_pkg::ST_RESP;
          end else begin
            state_nxt = skt_pkg::ST_SH0;
          end
        end
      end
      skt_pkg::ST_SH0:    state_nxt = skt_pkg::ST_SHIFT;
      skt_pkg::ST_SHIFT:  if (idx_r == slot_r) state_nxt = skt_pkg::ST_RESP;
      skt_pkg::ST_DL0:    state_nxt = skt_pkg::ST_DSHIFT;
      skt_pkg::ST_DSHIFT: if (!(idx_p1 < used_r)) state_nxt = skt_pkg::ST_RESP;
      skt_pkg::ST_RESP:   if (can_load) state_nxt = skt_pkg::ST_IDLE;
      default:            state_nxt = skt_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt       = cmd_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    key_nxt       = key_r;
    tod_nxt       = tod_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    waddr         = idx_r[skt_pkg::IDX_W-1:0];
    wdata         = rdata_r;
    raddr         = '0;
    unique case (state_r)
      skt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          key_nxt    = skt_pkg::norm_key(in_data.plate_key);
          tod_nxt    = {in_data.hour, in_data.minute, in_data.second};
          status_nxt = skt_pkg::STS_DONE;
          found_nxt  = 1'b0;
          idx_nxt    = '0;
          if (in_cmd == skt_pkg::CMD_CLEAR) begin
            used_nxt = '0;
          end
          if (in_cmd == skt_pkg::CMD_DELETE) begin
            idx_nxt = skt_pkg::CNT_W'(32'(in_data.position) - 1);
            if (pos_bad) begin
              status_nxt = skt_pkg::STS_BAD_POS;
            end
          end
        end
      end
      skt_pkg::ST_SRCH: begin
        raddr = idx_p1[skt_pkg::IDX_W-1:0];
        if (stop) begin
          slot_nxt = idx_r;
          if (cmd_r == skt_pkg::CMD_EXISTS) begin
            found_nxt = match;
          end else if (match) begin
            status_nxt = skt_pkg::STS_DUP;
          end else if (32'(used_r) >= skt_pkg::CAPACITY) begin
            status_nxt = skt_pkg::STS_FULL;
          end else begin
            idx_nxt = used_r;
          end
        end else begin
          idx_nxt = idx_p1;
        end
      end
      skt_pkg::ST_SH0: begin
        raddr = idx_m1[skt_pkg::IDX_W-1:0];
      end
      skt_pkg::ST_SHIFT: begin
        mem_we = 1'b1;
        if (idx_r != slot_r) begin
          raddr   = idx_m2[skt_pkg::IDX_W-1:0];
          idx_nxt = idx_m1;
        end else begin
          wdata    = '{key: key_r, tod: tod_r};
          used_nxt = used_r + skt_pkg::CNT_W'(1);
        end
      end
      skt_pkg::ST_DL0: begin
        raddr = idx_p1[skt_pkg::IDX_W-1:0];
      end
      skt_pkg::ST_DSHIFT: begin
        if (idx_p1 < used_r) begin
          mem_we  = 1'b1;
          raddr   = idx_p2[skt_pkg::IDX_W-1:0];
          idx_nxt = idx_p1;
        end else begin
          used_nxt = used_r - skt_pkg::CNT_W'(1);
        end
      end
      skt_pkg::ST_RESP: begin
        if (can_load) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.found       = found_r;
          out_data_nxt.entry_count = 7'(used_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    key_r      <= key_nxt;
    tod_r      <= tod_nxt;
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for sorted_key_table
// Drives insert, exists, delete, count and clear beats through the valid/stall
// input channel and checks every result beat against its planned value or a
// software copy of the ordered key table. A directed table leads random fill,
// blend, drain rounds. Both sides idle at random but in the first blend round.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam int MIX_FILL  = 0;
  localparam int MIX_BLEND = 1;
  localparam int MIX_DRAIN = 2;

  typedef struct {
    skt_pkg::in_beat_t  beat;
    bit                 typed;
    skt_pkg::out_beat_t want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  skt_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  skt_pkg::out_beat_t out_data;

  logic [skt_pkg::KEY_W-1:0]  tbl_key [skt_pkg::CAPACITY];
  logic [skt_pkg::TIME_W-1:0] tbl_tod [skt_pkg::CAPACITY];
  logic [skt_pkg::CNT_W-1:0]  tbl_count = '0;

  skt_pkg::out_beat_t pending [$];
  plan_row_t          plan [$];
  skt_pkg::out_beat_t head;
  int                 misses = 0;
  bit                 quiet = 1'b0;

  sorted_key_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bytes after the string terminator never take part in ordering
  function automatic logic [skt_pkg::KEY_W-1:0] plate_canon(
      input logic [skt_pkg::KEY_W-1:0] raw);
    logic [skt_pkg::KEY_W-1:0] keep;
    keep = '0;
    for (int n = 0; n < skt_pkg::KEY_CHARS; n++) begin
      if (raw[skt_pkg::KEY_W-1-8*n -: 8] == 8'h00) break;
      keep[skt_pkg::KEY_W-1-8*n -: 8] = raw[skt_pkg::KEY_W-1-8*n -: 8];
    end
    return keep;
  endfunction

  function automatic skt_pkg::out_beat_t table_step(input skt_pkg::in_beat_t b);
    skt_pkg::out_beat_t        r;
    logic [skt_pkg::KEY_W-1:0] k;
    int                        slot;
    bit                        hit;
    r    = '0;
    k    = plate_canon(b.plate_key);
    slot = 0;
    while (slot < tbl_count && tbl_key[slot] < k) slot++;
    hit = (slot < tbl_count) ? (tbl_key[slot] == k) : 1'b0;
    case (b.cmd)
      skt_pkg::CMD_INSERT: begin
        if (hit) begin
          r.status = skt_pkg::STS_DUP;
        end else if (tbl_count >= skt_pkg::CAPACITY) begin
          r.status = skt_pkg::STS_FULL;
        end else begin
          for (int j = tbl_count; j > slot; j--) begin
            tbl_key[j] = tbl_key[j-1];
            tbl_tod[j] = tbl_tod[j-1];
          end
          tbl_key[slot] = k;
          tbl_tod[slot] = {b.hour, b.minute, b.second};
          tbl_count++;
        end
      end
      skt_pkg::CMD_EXISTS: r.found = hit;
      skt_pkg::CMD_DELETE: begin
        if (b.position == 0 || b.position > tbl_count) begin
          r.status = skt_pkg::STS_BAD_POS;
        end else begin
          for (int j = b.position - 1; j + 1 < tbl_count; j++) begin
            tbl_key[j] = tbl_key[j+1];
            tbl_tod[j] = tbl_tod[j+1];
          end
          tbl_count--;
        end
      end
      skt_pkg::CMD_CLEAR: tbl_count = '0;
      default: ;
    endcase
    r.entry_count = tbl_count;
    return r;
  endfunction

  function automatic plan_row_t mk(input logic [2:0] c, input logic [63:0] k,
                                   input int h, input int m,
                                   input int s, input int p,
                                   input int typed, input logic [1:0] st,
                                   input int fnd, input int cnt);
    plan_row_t row;
    row.beat  = '{cmd: c, plate_key: k, hour: 5'(h), minute: 6'(m), second: 6'(s),
                  position: 7'(p)};
    row.typed = (typed != 0);
    row.want  = '{status: st, found: 1'(fnd), entry_count: 7'(cnt)};
    return row;
  endfunction

  function automatic logic [skt_pkg::KEY_W-1:0] rand_plate(input int pool_pct);
    logic [skt_pkg::KEY_W-1:0] k;
    int                        pick;
    int                        len;
    bit                        ended;
    k    = '0;
    pick = $urandom_range(0, 99);
    if (pick < pool_pct && tbl_count != 0) begin
      k = tbl_key[$urandom_range(0, tbl_count - 1)];
    end else if (pick < pool_pct + 15) begin
      k = {$urandom, $urandom};
    end else begin
      len = $urandom_range(0, skt_pkg::KEY_CHARS);
      for (int n = 0; n < len; n++)
        k[skt_pkg::KEY_W-1-8*n -: 8] = 8'($urandom_range(8'h30, 8'h5a));
    end
    if ($urandom_range(0, 3) == 0) begin
      ended = 1'b0;
      for (int n = 0; n < 8; n++) begin
        if (ended) k[skt_pkg::KEY_W-1-8*n -: 8] = 8'($urandom_range(0, 255));
        else if (k[skt_pkg::KEY_W-1-8*n -: 8] == 8'h00) ended = 1'b1;
      end
    end
    return k;
  endfunction

  function automatic skt_pkg::in_beat_t rand_beat(input int mix);
    skt_pkg::in_beat_t b;
    int                roll;
    int                c_ins, c_ex, c_del, c_cnt, c_clr;
    int                p;
    case (mix)
      MIX_FILL:  begin c_ins = 75; c_ex = 87; c_del = 93; c_cnt = 97; c_clr = 98; end
      MIX_BLEND: begin c_ins = 40; c_ex = 65; c_del = 88; c_cnt = 94; c_clr = 96; end
      default:   begin c_ins = 15; c_ex = 30; c_del = 88; c_cnt = 95; c_clr = 97; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < c_ins)      b.cmd = skt_pkg::CMD_INSERT;
    else if (roll < c_ex)  b.cmd = skt_pkg::CMD_EXISTS;
    else if (roll < c_del) b.cmd = skt_pkg::CMD_DELETE;
    else if (roll < c_cnt) b.cmd = skt_pkg::CMD_COUNT;
    else if (roll < c_clr) b.cmd = skt_pkg::CMD_CLEAR;
    else                   b.cmd = 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
    b.plate_key = rand_plate((b.cmd == skt_pkg::CMD_INSERT && mix == MIX_FILL) ? 10 : 45);
    if ($urandom_range(0, 99) < 85) begin
      b.hour   = 5'($urandom_range(0, 23));
      b.minute = 6'($urandom_range(0, 59));
      b.second = 6'($urandom_range(0, 59));
    end else begin
      b.hour   = 5'($urandom);
      b.minute = 6'($urandom);
      b.second = 6'($urandom);
    end
    p = $urandom_range(0, 99);
    if (p < 75 && tbl_count != 0) b.position = 7'($urandom_range(1, tbl_count));
    else if (p < 85)              b.position = '0;
    else if (p < 93)              b.position = tbl_count + 7'd1;
    else                          b.position = 7'($urandom_range(0, 127));
    return b;
  endfunction

  // entered and left at a falling edge
  task automatic drive_beat(input skt_pkg::in_beat_t b, input bit typed,
                            input skt_pkg::out_beat_t want);
    skt_pkg::out_beat_t calc;
    if (!quiet && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    calc = table_step(b);
    pending.push_back(typed ? want : calc);
    @(negedge clk);
  endtask

  task automatic drain_wait;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending.size() != 0);
  endtask

  task automatic check_field(input string name, input int got, input int exp);
    if (got != exp) begin
      misses++;
      if (misses <= 10)
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, name, got, exp);
    end
  endtask

  always @(negedge clk) begin
    out_stall <= rst_n && !quiet && ($urandom_range(0, 99) < 26);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        misses++;
        if (misses <= 10)
          $display("%0t unexpected result beat: status %0d found %0d count %0d",
                   $realtime, out_data.status, out_data.found, out_data.entry_count);
      end else begin
        head = pending.pop_front();
        check_field("status", int'(out_data.status), int'(head.status));
        check_field("found", int'(out_data.found), int'(head.found));
        check_field("entry_count", int'(out_data.entry_count), int'(head.entry_count));
      end
    end
  end

  initial begin
    #5000000;
    $display("sorted_key_table regression: fail");
    $finish;
  end

  initial begin
    plan.push_back(mk(skt_pkg::CMD_COUNT,  64'h0, 0, 0, 0, 0, 1,
                      skt_pkg::STS_DONE, 0, 0));
    plan.push_back(mk(skt_pkg::CMD_EXISTS, 64'h0, 0, 0, 0, 0, 1,
                      skt_pkg::STS_DONE, 0, 0));
    plan.push_back(mk(skt_pkg::CMD_DELETE, 64'h0, 0, 0, 0, 0, 1,
                      skt_pkg::STS_BAD_POS, 0, 0));
    plan.push_back(mk(skt_pkg::CMD_DELETE, 64'h0, 0, 0, 0, 1, 1,
                      skt_pkg::STS_BAD_POS, 0, 0));
    plan.push_back(mk(skt_pkg::CMD_INSERT, 64'h4142_4300_0000_0000, 23, 59, 59, 0, 1,
                      skt_pkg::STS_DONE, 0, 1));
    plan.push_back(mk(skt_pkg::CMD_INSERT, 64'h4142_4300_0000_0000, 1, 2, 3, 0, 1,
                      skt_pkg::STS_DUP, 0, 1));
    // junk past the terminator still matches
    plan.push_back(mk(skt_pkg::CMD_INSERT, 64'h4142_4300_ffff_ffff, 4, 5, 6, 0, 1,
                      skt_pkg::STS_DUP, 0, 1));
    plan.push_back(mk(skt_pkg::CMD_EXISTS, 64'h4142_4300_1234_5678, 0, 0, 0, 0, 1,
                      skt_pkg::STS_DONE, 1, 1));
    plan.push_back(mk(skt_pkg::CMD_INSERT, 64'hffff_ffff_ffff_ffff, 31, 63, 63, 127, 1,
                      skt_pkg::STS_DONE, 0, 2));
    plan.push_back(mk(skt_pkg::CMD_INSERT, 64'h0, 0, 0, 0, 0, 1,
                      skt_pkg::STS_DONE, 0, 3));
    plan.push_back(mk(skt_pkg::CMD_INSERT, 64'h00ff_ffff_ffff_ffff, 9, 9, 9, 0, 1,
                      skt_pkg::STS_DUP, 0, 3));
    plan.push_back(mk(skt_pkg::CMD_INSERT, 64'h0100_0000_0000_0000, 12, 30, 0, 0, 1,
                      skt_pkg::STS_DONE, 0, 4));
    plan.push_back(mk(skt_pkg::CMD_EXISTS, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 0, 1,
                      skt_pkg::STS_DONE, 1, 4));
    plan.push_back(mk(skt_pkg::CMD_EXISTS, 64'h0100_dead_beef_0000, 0, 0, 0, 0, 0,
                      skt_pkg::STS_DONE, 0, 0));
    plan.push_back(mk(skt_pkg::CMD_EXISTS, 64'h4142_4400_0000_0000, 0, 0, 0, 0, 0,
                      skt_pkg::STS_DONE, 0, 0));
    plan.push_back(mk(CMD_RSVD5, 64'h4142_4300_0000_0000, 0, 0, 0, 1, 1,
                      skt_pkg::STS_DONE, 0, 4));
    plan.push_back(mk(CMD_RSVD5 + 3'd1, 64'h0, 0, 0, 0, 2, 1,
                      skt_pkg::STS_DONE, 0, 4));
    plan.push_back(mk(CMD_RSVD7, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 3, 1,
                      skt_pkg::STS_DONE, 0, 4));
    plan.push_back(mk(skt_pkg::CMD_DELETE, 64'h0, 0, 0, 0, 5, 1,
                      skt_pkg::STS_BAD_POS, 0, 4));
    plan.push_back(mk(skt_pkg::CMD_DELETE, 64'h0, 0, 0, 0, 127, 1,
                      skt_pkg::STS_BAD_POS, 0, 4));
    plan.push_back(mk(skt_pkg::CMD_DELETE, 64'h0, 0, 0, 0, 4, 1,
                      skt_pkg::STS_DONE, 0, 3));
    plan.push_back(mk(skt_pkg::CMD_DELETE, 64'h0, 0, 0, 0, 1, 1,
                      skt_pkg::STS_DONE, 0, 2));
    plan.push_back(mk(skt_pkg::CMD_EXISTS, 64'h4142_4300_0000_0000, 0, 0, 0, 0, 0,
                      skt_pkg::STS_DONE, 0, 0));
    plan.push_back(mk(skt_pkg::CMD_COUNT,  64'h0, 0, 0, 0, 0, 1,
                      skt_pkg::STS_DONE, 0, 2));
    plan.push_back(mk(skt_pkg::CMD_CLEAR,  64'hffff_ffff_ffff_ffff, 0, 0, 0, 0, 1,
                      skt_pkg::STS_DONE, 0, 0));
    plan.push_back(mk(skt_pkg::CMD_EXISTS, 64'h4142_4300_0000_0000, 0, 0, 0, 0, 1,
                      skt_pkg::STS_DONE, 0, 0));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) drive_beat(plan[i].beat, plan[i].typed, plan[i].want);
    drain_wait();

    repeat (120) drive_beat(rand_beat(MIX_FILL), 1'b0, '0);
    drain_wait();
    quiet = 1'b1;
    repeat (100) drive_beat(rand_beat(MIX_BLEND), 1'b0, '0);
    drain_wait();
    quiet = 1'b0;
    repeat (100) drive_beat(rand_beat(MIX_DRAIN), 1'b0, '0);
    drain_wait();
    repeat (110) drive_beat(rand_beat(MIX_FILL), 1'b0, '0);
    drain_wait();
    repeat (70) drive_beat(rand_beat(MIX_BLEND), 1'b0, '0);
    in_valid <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (2 * skt_pkg::CAPACITY + 8) @(posedge clk);
    if (misses == 0 && pending.size() == 0) begin
      $display("sorted_key_table regression: pass");
    end else begin
      $display("sorted_key_table regression: fail");
    end
    $finish;
  end

endmodule
